[rtl/lcmsf_pkg.sv]
// shared constants and the rounding/saturation helper for the load cell median spike filter
// no dependencies
`default_nettype none

package lcmsf_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd6;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [16:0] GAIN_ONE = 17'd65536;
  localparam logic [15:0] TIMEOUT_MIN = 16'd10;
  localparam logic [15:0] AGE_MAX = 16'hFFFF;
  localparam logic signed [MUL_W-1:0] GRAVITY_Q16 = 33'sd642689;

  // round to nearest (halves up) by 2^8 or 2^16, then saturate to 32 bits
  function automatic logic signed [31:0] rnd_sat(input logic signed [PROD_W:0] x,
                                                 input logic sh16);
    logic signed [PROD_W:0] y;
    logic signed [PROD_W:0] q;
    y = x + (sh16 ? (PROD_W+1)'(32768) : (PROD_W+1)'(128));
    q = sh16 ? (y >>> 16) : (y >>> 8);
    if (q > (PROD_W+1)'(64'sh7FFFFFFF)) begin
      return 32'sh7FFFFFFF;
    end else if (q < -(PROD_W+1)'(64'sh80000000)) begin
      return 32'sh80000000;
    end else begin
      return q[31:0];
    end
  endfunction

endpackage

`default_nettype wire

[rtl/load_cell_median_spike_filter.sv]
// Load cell median spike filter: sequencer, window, configuration and result register.
// Uses lcmsf_pkg, lcmsf_rank (median search) and lcmsf_mul (shared multiplier).
//
// Input words (in_valid/in_ready) are either a sample (operation 0) or a 1 ms tick.
// One word produces exactly one result word on out_valid/out_ready.
// Config writes (cfg_write_enable, cfg_index, cfg_data) are for idle only; the
// user must keep to this, since the block itself does not enforce it.
// A tick or an incomplete sample goes straight to S_DONE, which loads the result
// register once the output register is free and then returns to S_IDLE.
// A sample walks the window once for the spike check (once it holds three or more
// entries), again for the new median, then uses the shared multiplier for mass,
// two EMA products (not on the first, seeding sample) and force; a spike ends it
// early. The window rank search and the single multiplier set how long it takes.
// in_ready is high only while the sequencer is idle; one word is in work at a time.
// The finished word sits in an output register; a stalled receiver holds it while
// the next word is accepted and processed, and only the final handoff waits.
// Synchronous reset clears the window, filter state, counters and registers to
// their defaults and empties the output register.
`default_nettype none

module load_cell_median_spike_filter
  import lcmsf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          operation,
  input  wire logic signed [SAMPLE_BITS-1:0] positive_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] negative_sample,
  input  wire logic                          positive_present,
  input  wire logic                          negative_present,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [16:0]                 filtered_counts,
  output logic signed [31:0]                 mass_value,
  output logic signed [31:0]                 force_value,
  output logic                               result_valid,
  output logic [31:0]                        spike_total,
  output logic                               sample_accepted,
  input  wire logic                          cfg_write_enable,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int RAW_W = SAMPLE_BITS + 1;
  localparam int IW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH+1);

  typedef enum logic [3:0] {
    S_IDLE, S_MED1, S_CHECK, S_INSERT, S_MED2, S_M1, S_M2,
    S_E1, S_E2, S_E3, S_F1, S_F2, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic               diff_mode;
  logic signed [16:0] tare;
  logic signed [31:0] scale;
  logic [15:0]        deadband;
  logic [15:0]        spike_limit;
  logic [16:0]        gain;
  logic [15:0]        timeout;

  // filter state
  logic signed [RAW_W-1:0] win [WINDOW_DEPTH];
  logic [FW-1:0]           fill;
  logic [IW-1:0]           slot;
  logic [IW-1:0]           cand;
  logic signed [RAW_W-1:0] raw;
  logic signed [RAW_W-1:0] med;
  logic signed [RAW_W-1:0] median_counts;
  logic signed [31:0]      smoothed;
  logic signed [31:0]      force_q;
  logic signed [31:0]      mass_q;
  logic signed [PROD_W-1:0] ema_p1;
  logic                    seeded;
  logic                    valid_flag;
  logic [31:0]             spike_counter;
  logic [15:0]             ms_age;
  logic                    seen;
  logic                    accepted;

  logic hit;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  lcmsf_rank #(.DEPTH(WINDOW_DEPTH), .RAW_W(RAW_W)) u_rank (
    .win(win), .cand(cand), .fill(fill), .hit(hit)
  );

  lcmsf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  // combinational helpers
  logic [16:0]        gain_c;
  logic [15:0]        timeout_c;
  logic [15:0]        ms_next;
  logic signed [RAW_W-1:0] raw_next;
  logic signed [31:0] dev;
  logic [31:0]        dev_abs;
  logic signed [31:0] delta;
  logic [31:0]        delta_abs;
  logic signed [31:0] delta_db;
  logic signed [31:0] mass_c;
  logic signed [31:0] ema_c;
  logic signed [31:0] force_c;
  logic               neg_ok;
  logic               scale_nz;

  assign gain_c = (gain > GAIN_ONE) ? GAIN_ONE : gain;
  assign timeout_c = (timeout < TIMEOUT_MIN) ? TIMEOUT_MIN : timeout;
  assign ms_next = (ms_age < AGE_MAX) ? ms_age + 16'd1 : ms_age;
  assign raw_next = diff_mode ? RAW_W'(positive_sample) - RAW_W'(negative_sample)
                              : RAW_W'(positive_sample);
  assign neg_ok = !diff_mode || negative_present;
  assign scale_nz = (scale != 32'sd0);

  assign dev = 32'(raw) - 32'(med);
  assign dev_abs = dev[31] ? 32'(-dev) : 32'(dev);
  assign delta = 32'(median_counts) - 32'(tare);
  assign delta_abs = delta[31] ? 32'(-delta) : 32'(delta);
  assign delta_db = (delta_abs < {16'd0, deadband}) ? 32'sd0 : delta;

  assign mass_c = rnd_sat((PROD_W+1)'(mul_p), 1'b0);
  assign ema_c = rnd_sat((PROD_W+1)'(ema_p1) + (PROD_W+1)'(mul_p), 1'b1);
  assign force_c = rnd_sat((PROD_W+1)'(mul_p), 1'b1);

  always_comb begin
    case (state)
      S_M1: begin
        mul_a = MUL_W'(delta_db);
        mul_b = MUL_W'(scale);
      end
      S_E1: begin
        mul_a = MUL_W'($signed({1'b0, gain_c}));
        mul_b = MUL_W'(mass_q);
      end
      S_E2: begin
        mul_a = MUL_W'($signed({1'b0, GAIN_ONE - gain_c}));
        mul_b = MUL_W'(smoothed);
      end
      S_F1: begin
        mul_a = MUL_W'(smoothed);
        mul_b = GRAVITY_Q16;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      diff_mode <= 1'b1;
      tare <= '0;
      scale <= '0;
      deadband <= 16'd2;
      spike_limit <= 16'd120;
      gain <= 17'd5243;
      timeout <= 16'd200;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win[i] <= '0;
      end
      fill <= '0;
      slot <= '0;
      cand <= '0;
      median_counts <= '0;
      smoothed <= '0;
      force_q <= '0;
      seeded <= 1'b0;
      valid_flag <= 1'b0;
      spike_counter <= '0;
      ms_age <= '0;
      seen <= 1'b0;
      accepted <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_write_enable) begin
        case (cfg_index)
          CFG_DIFF_MODE: diff_mode <= cfg_data[0];
          CFG_TARE:      tare <= cfg_data[16:0];
          CFG_SCALE:     scale <= cfg_data[31:0];
          CFG_DEADBAND:  deadband <= cfg_data[15:0];
          CFG_SPIKE_LIM: spike_limit <= cfg_data[15:0];
          CFG_GAIN:      gain <= cfg_data[16:0];
          CFG_TIMEOUT:   timeout <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            accepted <= 1'b0;
            cand <= '0;
            if (operation == OP_TICK) begin
              if (seen) begin
                ms_age <= ms_next;
                if (ms_next > timeout_c) valid_flag <= 1'b0;
              end
              state <= S_DONE;
            end else if (!positive_present || !neg_ok) begin
              valid_flag <= 1'b0;
              state <= S_DONE;
            end else begin
              raw <= raw_next;
              ms_age <= '0;
              seen <= 1'b1;
              state <= (fill >= FW'(3)) ? S_MED1 : S_INSERT;
            end
          end
        end
        S_MED1: begin
          if (hit) begin
            med <= win[cand];
            state <= S_CHECK;
          end else begin
            cand <= cand + IW'(1);
          end
        end
        S_CHECK: begin
          if (dev_abs > {16'd0, spike_limit}) begin
            spike_counter <= spike_counter + 32'd1;
            valid_flag <= scale_nz;
            state <= S_DONE;
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          win[slot] <= raw;
          slot <= (slot == IW'(WINDOW_DEPTH-1)) ? '0 : slot + IW'(1);
          if (fill < FW'(WINDOW_DEPTH)) fill <= fill + FW'(1);
          cand <= '0;
          state <= S_MED2;
        end
        S_MED2: begin
          if (hit) begin
            median_counts <= win[cand];
            state <= S_M1;
          end else begin
            cand <= cand + IW'(1);
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin
          if (!seeded) begin
            smoothed <= mass_c;
            seeded <= 1'b1;
            state <= S_F1;
          end else begin
            mass_q <= mass_c;
            state <= S_E1;
          end
        end
        S_E1: state <= S_E2;
        S_E2: begin
          ema_p1 <= mul_p;
          state <= S_E3;
        end
        S_E3: begin
          smoothed <= ema_c;
          state <= S_F1;
        end
        S_F1: state <= S_F2;
        S_F2: begin
          force_q <= force_c;
          valid_flag <= scale_nz;
          accepted <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            filtered_counts <= 17'(32'(median_counts));
            mass_value <= smoothed;
            force_value <= force_q;
            result_valid <= valid_flag;
            spike_total <= spike_counter;
            sample_accepted <= accepted;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW_DEPTH)) else $error("window fill beyond depth");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot < IW'(WINDOW_DEPTH)) else $error("window slot out of range");

  a_spike_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(spike_counter) |-> spike_counter == $past(spike_counter) + 32'd1)
    else $error("spike counter jumped");

  a_slot_fill: assert property (@(posedge clk) disable iff (rst)
    fill < FW'(WINDOW_DEPTH) |-> FW'(slot) == fill)
    else $error("slot and fill disagree while filling");

endmodule

`default_nettype wire

[rtl/lcmsf_mul.sv]
// shared signed multiplier with registered product
// uses lcmsf_pkg for operand widths
`default_nettype none

module lcmsf_mul
  import lcmsf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  a,
  input  wire logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

[rtl/lcmsf_rank.sv]
// rank test of one window entry: flags the entry sitting at the median position
// no package dependencies
`default_nettype none

module lcmsf_rank #(
  parameter int DEPTH = 5,
  parameter int RAW_W = 17
) (
  input  wire logic signed [RAW_W-1:0]          win [DEPTH],
  input  wire logic [$clog2(DEPTH)-1:0]         cand,
  input  wire logic [$clog2(DEPTH+1)-1:0]       fill,
  output logic                                  hit
);

  localparam int IW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH+1);

  logic signed [RAW_W-1:0] v;
  logic [FW-1:0] cnt;

  assign v = win[cand];

  always_comb begin
    cnt = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (FW'(j) < fill) begin
        if (win[j] < v || (win[j] == v && IW'(j) < cand)) begin
          cnt = cnt + FW'(1);
        end
      end
    end
    hit = (cnt == (fill >> 1));
  end

endmodule

`default_nettype wire
